// ===== sv/tanh_saturator_with_tone_filter_core_macros.svh =====
// Assertion macros shared by the checker of the tanh saturator core.
`ifndef TANH_SATURATOR_WITH_TONE_FILTER_CORE_MACROS_SVH
`define TANH_SATURATOR_WITH_TONE_FILTER_CORE_MACROS_SVH

// Same-cycle implication, idle during reset.
`define TSTF_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, idle during reset.
`define TSTF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/tstf_pkg.sv =====
// Package: register indexes, reset values and tanh table generation for the saturator core.
package tstf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BYPASS = 3'd0;
    localparam t_cfg_idx CFG_BIAS   = 3'd1;
    localparam t_cfg_idx CFG_DRIVE  = 3'd2;
    localparam t_cfg_idx CFG_MIX    = 3'd3;
    localparam t_cfg_idx CFG_OGAIN  = 3'd4;
    localparam t_cfg_idx CFG_B0     = 3'd5;
    localparam t_cfg_idx CFG_A1     = 3'd6;
    localparam t_cfg_idx CFG_A2     = 3'd7;

    localparam logic [15:0] RST_DRIVE = 16'd22528;
    localparam logic [16:0] RST_MIX   = 17'd65536;
    localparam logic [15:0] RST_OGAIN = 16'd16384;
    localparam logic [22:0] RST_B0    = 23'd4194304;

    localparam int DEF_NUM_CHANNELS = 2;
    localparam int DEF_TANH_ENTRIES = 256;

    // Bits of the table index k that the power loop walks (k below 8192).
    localparam int TANH_K_W = 13;

    localparam logic [63:0] FX_ONE = 64'h1000_0000_0000_0000;

    // (a*b) >> 60, truncated.
    function automatic logic [63:0] fx_mul60(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[123:60];
    endfunction

    // Restoring shift-subtract division, used only while building the table.
    function automatic logic [63:0] fx_udiv(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4k/n) in Q1.23: e = exp(-8/n)^k from a series, then (1-e)/(1+e).
    function automatic logic [23:0] tanh_point(int k, int n);
        logic [63:0] d;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] base;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [31:0] p;
        d    = fx_udiv(64'h8000_0000_0000_0000, 64'(n));
        term = FX_ONE;
        r    = FX_ONE;
        for (int j = 1; j <= 24; j++) begin
            term = fx_udiv(fx_mul60(term, d), 64'(j));
            if (j[0]) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        e    = FX_ONE;
        base = r;
        p    = 32'(k);
        for (int b = 0; b < TANH_K_W; b++) begin
            if (p[b]) begin
                e = fx_mul60(e, base);
            end
            base = fx_mul60(base, base);
        end
        num = (FX_ONE - e) >> 20;
        den = (FX_ONE + e) >> 20;
        q   = fx_udiv((num << 23) + (den >> 1), den);
        return q[23:0];
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [39:0] v);
        if (v > 40'sh007FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < 40'shFF80000000) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== sv/tanh_saturator_with_tone_filter_core.sv =====
// Top level: tanh waveshaper with per-channel lowpass, mix, output gain and clamp.
//
//  channel   | direction | beat holds
//  ----------+-----------+-------------------------------------------
//  s_axis    | in        | tuser: chan_index, tdata: sample_in
//  m_axis    | out       | tuser: chan_out,   tdata: sample_out
//  i_cfg_*   | in        | register index and value, one write a cycle
//
// An item steps through the sequencer states from accept to the result register (bypass
// skips to the output state): every product goes through one shared 33x25 multiplier in
// turn, and the tanh table is a single-port ROM read twice. Filter state sits in a 64-bit
// memory, one entry per channel, read on accept and written back once. Reset clears the
// entry valid bits, so no clearing pass is needed. A stalled result waits in the output
// register while the next beat is already taken.
module tanh_saturator_with_tone_filter_core
    import tstf_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int TANH_ENTRIES = DEF_TANH_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // [23:0] sample_in
    input  logic                  s_axis_tuser,   // [0] chan_index
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [23:0] sample_out
    output logic                  m_axis_tuser,   // [0] chan_out
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IDX_W  = $clog2(TANH_ENTRIES + 1);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_DRV  = 5'd1;
    localparam logic [4:0] ST_ABS  = 5'd2;
    localparam logic [4:0] ST_IDX  = 5'd3;
    localparam logic [4:0] ST_ROM0 = 5'd4;
    localparam logic [4:0] ST_ROM1 = 5'd5;
    localparam logic [4:0] ST_INTP = 5'd6;
    localparam logic [4:0] ST_TANH = 5'd7;
    localparam logic [4:0] ST_B0T  = 5'd8;
    localparam logic [4:0] ST_YOUT = 5'd9;
    localparam logic [4:0] ST_A1Y  = 5'd10;
    localparam logic [4:0] ST_A2Y  = 5'd11;
    localparam logic [4:0] ST_S2   = 5'd12;
    localparam logic [4:0] ST_MIXY = 5'd13;
    localparam logic [4:0] ST_MIXD = 5'd14;
    localparam logic [4:0] ST_GAIN = 5'd15;
    localparam logic [4:0] ST_OUT  = 5'd16;

    // configuration
    logic               r_bypass;
    logic signed [20:0] r_bias;
    logic [15:0]        r_drive;
    logic [16:0]        r_mix;
    logic [15:0]        r_ogain;
    logic [22:0]        r_b0;
    logic signed [23:0] r_a1;
    logic signed [23:0] r_a2;

    // control
    logic [4:0] r_state, n_state;
    logic       r_m_valid;

    // item and datapath
    logic               r_chan;
    logic signed [23:0] r_x;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_byp;
    logic [63:0]        r_st_q;
    logic               r_st_hit;
    logic [24:0]        r_abs;
    logic               r_neg;
    logic               r_sat;
    logic [IDX_W-1:0]   r_idx;
    logic [24:0]        r_frac;
    logic [23:0]        r_rom;
    logic [23:0]        r_lo;
    logic signed [24:0] r_t;
    logic signed [47:0] r_bt;
    logic signed [31:0] r_y;
    logic signed [31:0] r_s1n;
    logic signed [41:0] r_acc;
    logic signed [31:0] r_mixed;
    logic signed [57:0] r_prod;
    logic [23:0]        r_m_data;
    logic               r_m_user;

    // state memory and tanh table
    logic [63:0]             r_st_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_st_vld;
    logic [23:0]             w_tanh_rom [TANH_ENTRIES+1];

    logic                w_in_acc;
    logic                w_out_load;
    logic                w_st_we;
    logic [SLOT_W-1:0]   w_slot;
    logic                w_mul_en;
    logic signed [32:0]  w_mul_a;
    logic signed [24:0]  w_mul_b;
    logic signed [24:0]  w_biased;
    logic signed [57:0]  w_drv_acc;
    logic signed [29:0]  w_driven;
    logic [29:0]         w_drv_mag;
    logic [23:0]         w_tab_diff;
    logic signed [57:0]  w_int_acc;
    logic [23:0]         w_t_mag;
    logic signed [24:0]  w_t;
    logic signed [31:0]  w_s1_cur;
    logic signed [31:0]  w_s2_cur;
    logic signed [57:0]  w_y_acc;
    logic signed [31:0]  w_y;
    logic signed [57:0]  w_s1_acc;
    logic signed [31:0]  w_s1_new;
    logic signed [57:0]  w_s2_acc;
    logic signed [31:0]  w_s2_new;
    logic [16:0]         w_m_eff;
    logic [17:0]         w_one_minus;
    logic signed [57:0]  w_mix_acc;
    logic signed [57:0]  w_gain_acc;
    logic signed [43:0]  w_gain_sh;
    logic [23:0]         w_clamped;
    logic [23:0]         w_res;

    for (genvar gk = 0; gk <= TANH_ENTRIES; gk++) begin : g_tanh_rom
        localparam logic [23:0] TAB_VAL = tanh_point(gk, TANH_ENTRIES);
        assign w_tanh_rom[gk] = TAB_VAL;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == ST_OUT) && (!r_m_valid || m_axis_tready);
    assign w_st_we       = (r_state == ST_S2);
    assign w_slot        = (32'(s_axis_tuser) < NUM_CHANNELS) ? SLOT_W'(s_axis_tuser)
                                                              : SLOT_W'(NUM_CHANNELS - 1);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b0;
            r_bias   <= '0;
            r_drive  <= RST_DRIVE;
            r_mix    <= RST_MIX;
            r_ogain  <= RST_OGAIN;
            r_b0     <= RST_B0;
            r_a1     <= '0;
            r_a2     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BYPASS: r_bypass <= i_cfg_data[0];
                CFG_BIAS:   r_bias   <= i_cfg_data[20:0];
                CFG_DRIVE:  r_drive  <= i_cfg_data[15:0];
                CFG_MIX:    r_mix    <= i_cfg_data[16:0];
                CFG_OGAIN:  r_ogain  <= i_cfg_data[15:0];
                CFG_B0:     r_b0     <= i_cfg_data[22:0];
                CFG_A1:     r_a1     <= i_cfg_data[23:0];
                CFG_A2:     r_a2     <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = r_bypass ? ST_OUT : ST_DRV;
                end
            end
            ST_DRV:  n_state = ST_ABS;
            ST_ABS:  n_state = ST_IDX;
            ST_IDX:  n_state = ST_ROM0;
            ST_ROM0: n_state = ST_ROM1;
            ST_ROM1: n_state = ST_INTP;
            ST_INTP: n_state = ST_TANH;
            ST_TANH: n_state = ST_B0T;
            ST_B0T:  n_state = ST_YOUT;
            ST_YOUT: n_state = ST_A1Y;
            ST_A1Y:  n_state = ST_A2Y;
            ST_A2Y:  n_state = ST_S2;
            ST_S2:   n_state = ST_MIXY;
            ST_MIXY: n_state = ST_MIXD;
            ST_MIXD: n_state = ST_GAIN;
            ST_GAIN: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_st_vld  <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_st_we) begin
                r_st_vld[r_slot] <= 1'b1;
            end
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state)
            ST_DRV: begin
                w_mul_a = 33'(w_biased);
                w_mul_b = {9'd0, r_drive};
            end
            ST_IDX: begin
                w_mul_a = {8'd0, r_abs};
                w_mul_b = 25'(TANH_ENTRIES);
            end
            ST_INTP: begin
                w_mul_a = {8'd0, r_frac};
                w_mul_b = {1'b0, w_tab_diff};
            end
            ST_B0T: begin
                w_mul_a = 33'(r_t);
                w_mul_b = {2'b0, r_b0};
            end
            ST_A1Y: begin
                w_mul_a = 33'(r_y);
                w_mul_b = 25'(r_a1);
            end
            ST_A2Y: begin
                w_mul_a = 33'(r_y);
                w_mul_b = 25'(r_a2);
            end
            ST_S2: begin
                w_mul_a = 33'(r_x);
                w_mul_b = {7'd0, w_one_minus};
            end
            ST_MIXY: begin
                w_mul_a = 33'(r_y);
                w_mul_b = {8'd0, w_m_eff};
            end
            ST_GAIN: begin
                w_mul_a = 33'(r_mixed);
                w_mul_b = {9'd0, r_ogain};
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    // ---------------- datapath arithmetic ----------------
    assign w_biased  = 25'(r_x) + 25'(r_bias);

    // driven = round(biased * drive / 2^12)
    assign w_drv_acc = r_prod + 58'sd2048;
    assign w_driven  = $signed(w_drv_acc[41:12]);
    assign w_drv_mag = w_driven[29] ? 30'(-w_driven) : 30'(w_driven);

    // tanh interpolation between two table points
    assign w_tab_diff = r_rom - r_lo;
    assign w_int_acc  = r_prod + 58'sd16777216;
    assign w_t_mag    = r_sat ? 24'h800000 : (r_lo + {1'b0, w_int_acc[47:25]});
    assign w_t        = r_neg ? -$signed({1'b0, w_t_mag}) : $signed({1'b0, w_t_mag});

    // lowpass, transposed direct form II
    assign w_s1_cur = r_st_hit ? $signed(r_st_q[63:32]) : 32'sd0;
    assign w_s2_cur = r_st_hit ? $signed(r_st_q[31:0])  : 32'sd0;
    assign w_y_acc  = r_prod + 58'sd2097152;
    assign w_y      = sat32(40'($signed(w_y_acc[47:22])) + 40'(w_s1_cur));
    assign w_s1_acc = (58'(r_bt) <<< 1) - r_prod + 58'sd2097152;
    assign w_s1_new = sat32(40'($signed(w_s1_acc[57:22])) + 40'(w_s2_cur));
    assign w_s2_acc = 58'(r_bt) - r_prod + 58'sd2097152;
    assign w_s2_new = sat32(40'($signed(w_s2_acc[57:22])));

    // dry/wet mix, fractions above full act as full
    assign w_m_eff     = r_mix[16] ? 17'h10000 : r_mix;
    assign w_one_minus = 18'h10000 - {1'b0, w_m_eff};
    assign w_mix_acc   = 58'(r_acc) + r_prod + 58'sd32768;

    // output gain and full-scale clamp
    assign w_gain_acc = r_prod + 58'sd8192;
    assign w_gain_sh  = $signed(w_gain_acc[57:14]);
    always_comb begin
        if (w_gain_sh > 44'sd8388607) begin
            w_clamped = 24'h7FFFFF;
        end else if (w_gain_sh < -44'sd8388608) begin
            w_clamped = 24'h800000;
        end else begin
            w_clamped = w_gain_sh[23:0];
        end
    end
    assign w_res = r_byp ? r_x : w_clamped;

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (w_in_acc) begin
            r_chan   <= s_axis_tuser;
            r_x      <= s_axis_tdata;
            r_slot   <= w_slot;
            r_byp    <= r_bypass;
            r_st_q   <= r_st_mem[w_slot];
            r_st_hit <= r_st_vld[w_slot];
        end
        if (r_state == ST_ABS) begin
            r_abs <= w_drv_mag[24:0];
            r_neg <= w_driven[29];
            r_sat <= |w_drv_mag[29:25];
        end
        if (r_state == ST_ROM0) begin
            r_rom  <= w_tanh_rom[r_prod[25 +: IDX_W]];
            r_idx  <= r_prod[25 +: IDX_W];
            r_frac <= r_prod[24:0];
        end
        if (r_state == ST_ROM1) begin
            r_lo  <= r_rom;
            r_rom <= w_tanh_rom[r_idx + IDX_W'(1)];
        end
        if (r_state == ST_TANH) begin
            r_t <= w_t;
        end
        if (r_state == ST_YOUT) begin
            r_bt <= r_prod[47:0];
            r_y  <= w_y;
        end
        if (r_state == ST_A2Y) begin
            r_s1n <= w_s1_new;
        end
        if (w_st_we) begin
            r_st_mem[r_slot] <= {r_s1n, w_s2_new};
        end
        if (r_state == ST_MIXY) begin
            r_acc <= r_prod[41:0];
        end
        if (r_state == ST_MIXD) begin
            r_mixed <= $signed(w_mix_acc[47:16]);
        end
        if (w_out_load) begin
            r_m_data <= w_res;
            r_m_user <= r_chan;
        end
    end

endmodule

// ===== sv/tstf_checker.sv =====
// Port-level checker for the tanh saturator core, bound to the top level.
`include "tanh_saturator_with_tone_filter_core_macros.svh"

module tstf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic       w_in_beat;
    logic       w_out_beat;
    logic [1:0] r_cnt, n_cnt;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_beat = m_axis_tvalid && m_axis_tready;

    // track beats taken but not yet delivered
    always_comb begin
        n_cnt = r_cnt;
        if (w_in_beat && !w_out_beat) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_in_beat && w_out_beat) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `TSTF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")
    `TSTF_ASSERT_NEXT(a_one_in_work, w_in_beat, !s_axis_tready, "second beat taken while one is in work")
    `TSTF_ASSERT_NOW(a_no_phantom, m_axis_tvalid, r_cnt != 2'd0, "output beat without a pending input")
    `TSTF_ASSERT_NOW(a_pending_bound, 1'b1, r_cnt != 2'd3, "more than two beats pending")

endmodule

bind tanh_saturator_with_tone_filter_core tstf_checker u_tstf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
